### sv/smm_norm_pkg.sv
// Shared types, sizes and codes for the min-max normalizer.
`timescale 1ns / 1ps

package smm_norm_pkg;

  localparam int SAMPLE_DEPTH = 32;
  localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);
  localparam int IDX_W  = $clog2(SAMPLE_DEPTH);
  localparam int SUM_W  = 23;
  localparam int LEN_W  = 7;
  localparam int DEN_W  = 16;
  localparam int DVD_W  = 22;
  localparam int STEP_W = 5;

  localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(DVD_W);
  localparam logic [STEP_W-1:0] NORM_STEPS = STEP_W'(16);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

  localparam logic [1:0] MODE_ADJUSTED  = 2'd0;
  localparam logic [1:0] MODE_CENTERED  = 2'd1;
  localparam logic [1:0] MODE_NORMALIZE = 2'd2;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [16:0]  value;
    logic [LEN_W-1:0]    length;
    logic signed [15:0]  max_value;
    logic signed [15:0]  min_value;
    logic signed [15:0]  mean_value;
    logic                flat_signal;
    logic                overflow;
    logic                end_of_frame;
  } result_t;

  typedef struct packed {
    logic              go;
    logic [DEN_W-1:0]  rem_init;
    logic [DVD_W-1:0]  dividend;
    logic [DEN_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

### sv/signal_min_max_normalizer.sv
// Min-max normalizer top level: configuration registers and block wiring.
//
// A sample request is taken when start is high and busy is low. Each sample is
// offset, scaled and saturated, stored (up to 32 per frame, extras dropped and
// flagged), and folded into running max, min and sum; after a sample that is
// not last, busy stays high for one cycle and the next request is taken once
// it falls. The request marked last closes the frame: a 22-step divide over
// the shared divider forms the mean, and then every stored sample comes out in
// order, each on result for exactly one cycle with strobe high. The receiver
// cannot stall the results. Each adjusted or centered result goes through a
// store read and then the output; a normalized result also waits for the
// 16-step divide of (x - min) by (max - min) in the one shared divider, except
// in a flat frame, where no divide runs. Frame statistics ride on the result
// with end_of_frame set. Write offset, scale and mode only while busy is low
// and no frame is being emitted.
`timescale 1ns / 1ps

module signal_min_max_normalizer import smm_norm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             item,
  output result_t              result,
  output logic                 strobe,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic signed [15:0] offset;
  logic signed [15:0] scale;
  logic [1:0]         mode;
  logic               accept;
  logic signed [15:0] adj;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= 16'sd0;
      scale  <= 16'sd256;
      mode   <= MODE_ADJUSTED;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET: offset <= cfg_data;
        REG_SCALE:  scale  <= cfg_data;
        REG_MODE:   mode   <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  assign accept = start && !busy;

  smm_norm_adjust u_adjust (
    .clk    (clk),
    .load   (accept),
    .sample (item.sample),
    .offset (offset),
    .scale  (scale),
    .adj    (adj)
  );

  smm_norm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  smm_norm_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .last    (item.last),
    .adj     (adj),
    .mode    (mode),
    .div_rsp (div_rsp),
    .div_req (div_req),
    .busy    (busy),
    .result  (result),
    .strobe  (strobe)
  );

endmodule

### sv/smm_norm_adjust.sv
// Offset, Q8.8 scale multiply, floor shift and 16-bit saturation of one sample.
`timescale 1ns / 1ps

module smm_norm_adjust import smm_norm_pkg::*; (
  input  logic               clk,
  input  logic               load,
  input  logic signed [15:0] sample,
  input  logic signed [15:0] offset,
  input  logic signed [15:0] scale,
  output logic signed [15:0] adj
);

  logic signed [16:0] sum17;
  logic signed [32:0] prod;
  logic [24:0]        shifted;
  logic [9:0]         hi;

  assign sum17 = {sample[15], sample} + {offset[15], offset};

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= sum17 * scale;
    end
  end

  // Arithmetic shift by 8 floors toward minus infinity.
  always_comb begin
    shifted = prod[32:8];
    hi      = shifted[24:15];
    if ((&hi) || !(|hi)) begin
      adj = shifted[15:0];
    end else if (shifted[24]) begin
      adj = 16'sh8000;
    end else begin
      adj = 16'sh7FFF;
    end
  end

endmodule

### sv/smm_norm_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module smm_norm_div import smm_norm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              active;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [DVD_W-1:0]  quo;
  logic [DEN_W:0]    rem2;
  logic [DEN_W:0]    diff;
  logic              ge;

  always_comb begin
    rem2 = {rem, quo[DVD_W-1]};
    ge   = rem2 >= {1'b0, den};
    diff = rem2 - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= !req.go && active && (cnt == STEP_W'(1));
      if (req.go) begin
        active <= 1'b1;
        cnt    <= req.steps;
        rem    <= req.rem_init;
        den    <= req.divisor;
        quo    <= req.dividend;
      end else if (active) begin
        rem <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
        quo <= {quo[DVD_W-2:0], ge};
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          active <= 1'b0;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

### sv/smm_norm_seq.sv
// Frame sequencer: sample store, running statistics and result generation.
`timescale 1ns / 1ps

module smm_norm_seq import smm_norm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               last,
  input  logic signed [15:0] adj,
  input  logic [1:0]         mode,
  input  div_rsp_t           div_rsp,
  output div_req_t           div_req,
  output logic               busy,
  output result_t            result,
  output logic               strobe
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ACC    = 7'b0000010,
    S_MSTART = 7'b0000100,
    S_MWAIT  = 7'b0001000,
    S_READ   = 7'b0010000,
    S_LOAD   = 7'b0100000,
    S_DWAIT  = 7'b1000000
  } state_t;

  state_t state;

  logic signed [15:0] mem [SAMPLE_DEPTH];
  logic signed [15:0] rd;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   idx;
  logic signed [15:0] run_max;
  logic signed [15:0] run_min;
  logic signed [SUM_W-1:0] run_sum;
  logic               dropped;
  logic               last_q;
  logic signed [15:0] mean;

  logic               room;
  logic               fin;
  logic               span_zero;
  logic               is_norm;
  logic               need_div;
  logic               emit;
  logic [16:0]        span17;
  logic [16:0]        d17;
  logic [16:0]        diff_c;
  logic [15:0]        cent;
  logic [SUM_W-1:0]   sum_mag;
  logic [15:0]        mean_mag;
  logic signed [16:0] value_next;
  result_t            res_next;

  always_comb begin
    room      = count < CNT_W'(SAMPLE_DEPTH);
    fin       = (CNT_W'(idx) + CNT_W'(1)) == count;
    span_zero = run_max == run_min;
    is_norm   = mode == MODE_NORMALIZE;
    need_div  = is_norm && !span_zero;
    span17    = {run_max[15], run_max} - {run_min[15], run_min};
    d17       = {rd[15], rd} - {run_min[15], run_min};
    diff_c    = {rd[15], rd} - {mean[15], mean};
    sum_mag   = run_sum[SUM_W-1] ? -run_sum : run_sum;
    mean_mag  = div_rsp.quotient[15:0];

    if (diff_c[16] == diff_c[15]) begin
      cent = diff_c[15:0];
    end else if (diff_c[16]) begin
      cent = 16'h8000;
    end else begin
      cent = 16'h7FFF;
    end

    // Mean divide when the frame closes, otherwise the per-sample fraction.
    div_req.divisor = span17[15:0];
    div_req.steps   = NORM_STEPS;
    div_req.rem_init = {1'b0, d17[15:1]};
    div_req.dividend = {d17[0], {(DVD_W-1){1'b0}}};
    div_req.go       = (state == S_LOAD) && need_div;
    if (state == S_MSTART) begin
      div_req.go       = 1'b1;
      div_req.divisor  = DEN_W'(count);
      div_req.steps    = MEAN_STEPS;
      div_req.rem_init = '0;
      div_req.dividend = sum_mag[DVD_W-1:0];
    end

    if (state == S_DWAIT) begin
      value_next = 17'(div_rsp.quotient);
    end else begin
      case (mode)
        MODE_CENTERED:  value_next = {cent[15], cent};
        MODE_NORMALIZE: value_next = '0;
        default:        value_next = {rd[15], rd};
      endcase
    end

    emit = ((state == S_LOAD) && !need_div) || ((state == S_DWAIT) && div_rsp.done);

    res_next.value        = value_next;
    res_next.length       = fin ? LEN_W'(count) : '0;
    res_next.max_value    = fin ? run_max : '0;
    res_next.min_value    = fin ? run_min : '0;
    res_next.mean_value   = fin ? mean : '0;
    res_next.flat_signal  = is_norm && span_zero;
    res_next.overflow     = fin && dropped;
    res_next.end_of_frame = fin;
  end

  always_ff @(posedge clk) begin
    if ((state == S_ACC) && room) begin
      mem[count[IDX_W-1:0]] <= adj;
    end
    rd <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      run_max <= 16'sh8000;
      run_min <= 16'sh7FFF;
      run_sum <= '0;
      dropped <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      strobe <= emit;
      case (state)
        S_IDLE: begin
          if (accept) begin
            last_q <= last;
            state  <= S_ACC;
          end
        end
        S_ACC: begin
          if (room) begin
            count   <= count + CNT_W'(1);
            run_sum <= run_sum + {{(SUM_W-16){adj[15]}}, adj};
            if (adj > run_max) run_max <= adj;
            if (adj < run_min) run_min <= adj;
          end else begin
            dropped <= 1'b1;
          end
          state <= last_q ? S_MSTART : S_IDLE;
        end
        S_MSTART: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (div_rsp.done) begin
            mean  <= run_sum[SUM_W-1] ? -mean_mag : mean_mag;
            idx   <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (need_div) begin
            state <= S_DWAIT;
          end
        end
        S_DWAIT: begin
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (emit) begin
        result <= res_next;
        if (fin) begin
          // Close the frame: drop the statistics and wait for the next one.
          count   <= '0;
          run_max <= 16'sh8000;
          run_min <= 16'sh7FFF;
          run_sum <= '0;
          dropped <= 1'b0;
          state   <= S_IDLE;
        end else begin
          idx   <= idx + IDX_W'(1);
          state <= S_READ;
        end
      end
    end
  end

  assign busy = state != S_IDLE;

endmodule

### sv/smm_norm_chk.sv
// Port-level checker for the min-max normalizer, bound to the top level.
`timescale 1ns / 1ps

module smm_norm_chk import smm_norm_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    strobe,
  input result_t result
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted request");

  a_mid_frame_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.end_of_frame |-> busy)
    else $error("mid-frame result while idle");

  a_eof_alone: assert property (@(posedge clk) disable iff (rst)
    strobe && result.end_of_frame |=> !strobe)
    else $error("result after end of frame");

  a_stats_final_only: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.end_of_frame |-> result.length == '0 && !result.overflow)
    else $error("statistics on a non-final result");

  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && result.flat_signal |-> result.value == '0)
    else $error("flat frame gave a nonzero value");

endmodule

bind signal_min_max_normalizer smm_norm_chk u_smm_norm_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

### dv/smm_norm_checker.sv
// Result checker for the min-max normalizer: snoops all ports, predicts frames, compares.
`timescale 1ns / 1ps

module smm_norm_checker import smm_norm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  in_item_t             item,
  input  result_t              result,
  input  logic                 strobe,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output int                   errors,
  output int                   pending
);

  localparam int MAX_PRINTS = 40;

  logic signed [15:0] offset_q;
  logic signed [15:0] scale_q;
  logic [1:0]         mode_q;

  logic signed [15:0] frame_store [SAMPLE_DEPTH];
  int                 frame_count;
  int                 frame_sum;
  logic signed [15:0] frame_max;
  logic signed [15:0] frame_min;
  logic               frame_dropped;
  logic signed [15:0] adjusted;

  result_t expected_results[$];
  result_t want;
  int      n_printed;

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Offset is exact, the product is floored by the arithmetic shift.
  function automatic logic signed [15:0] adjust_sample(input logic signed [15:0] x);
    longint shifted_in;
    longint product;
    shifted_in = longint'(x) + longint'(offset_q);
    product = shifted_in * longint'(scale_q);
    return clamp16(product >>> 8);
  endfunction

  task automatic clear_frame();
    frame_count = 0;
    frame_sum = 0;
    frame_max = 16'sh8000;
    frame_min = 16'sh7fff;
    frame_dropped = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] exp_val);
    errors++;
    if (n_printed < MAX_PRINTS) begin
      $display("ERROR at %0t: %s got %0d, expected %0d", $realtime, what, got, exp_val);
      n_printed++;
    end
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] exp_val);
    if (got !== exp_val) report_mismatch(name, got, exp_val);
  endtask

  // Queue one result per stored sample; stats go on the final one only.
  task automatic close_frame();
    int      mean;
    int      span;
    logic    flat;
    longint  v;
    result_t r;
    mean = (frame_count != 0) ? frame_sum / frame_count : 0;
    span = int'(frame_max) - int'(frame_min);
    flat = (mode_q == MODE_NORMALIZE) && (span == 0);
    for (int k = 0; k < frame_count; k++) begin
      case (mode_q)
        MODE_CENTERED:  v = clamp16(longint'(frame_store[k]) - longint'(mean));
        MODE_NORMALIZE: begin
          if (span <= 0) v = 0;
          else v = ((longint'(frame_store[k]) - longint'(frame_min)) * 32768) / span;
        end
        default:        v = frame_store[k];
      endcase
      r = '0;
      r.value = v[16:0];
      r.flat_signal = flat;
      if (k == frame_count - 1) begin
        r.length = LEN_W'(frame_count);
        r.max_value = frame_max;
        r.min_value = frame_min;
        r.mean_value = mean[15:0];
        r.overflow = frame_dropped;
        r.end_of_frame = 1'b1;
      end
      expected_results.insert(expected_results.size(), r);
    end
    clear_frame();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      offset_q = '0;
      scale_q = 16'sd256;
      mode_q = MODE_ADJUSTED;
      clear_frame();
      expected_results.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OFFSET: offset_q = cfg_data;
          REG_SCALE:  scale_q = cfg_data;
          REG_MODE:   mode_q = cfg_data[1:0];
          default:    ;
        endcase
      end

      if (strobe) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, value", result.value, 0);
        end else begin
          want = expected_results.pop_front();
          check_field("value", result.value, want.value);
          check_field("length", result.length, want.length);
          check_field("max_value", result.max_value, want.max_value);
          check_field("min_value", result.min_value, want.min_value);
          check_field("mean_value", result.mean_value, want.mean_value);
          check_field("flat_signal", result.flat_signal, want.flat_signal);
          check_field("overflow", result.overflow, want.overflow);
          check_field("end_of_frame", result.end_of_frame, want.end_of_frame);
        end
      end

      if (start && !busy) begin
        adjusted = adjust_sample(item.sample);
        if (frame_count < SAMPLE_DEPTH) begin
          frame_store[frame_count] = adjusted;
          frame_count++;
          if (adjusted > frame_max) frame_max = adjusted;
          if (adjusted < frame_min) frame_min = adjusted;
          frame_sum += adjusted;
        end else begin
          frame_dropped = 1'b1;
        end
        if (item.last) close_frame();
      end

      pending <= expected_results.size();
    end
  end

endmodule

### dv/testbench.sv
// Top of the min-max normalizer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import smm_norm_pkg::*;

  localparam int TOTAL_ITEMS = 250;
  localparam int SETTLE = 8;
  // Longest quiet stretch is the mean divide plus one normalized result and a pause.
  localparam int STALL_LIMIT = 2000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int FRAME_WIDE = 0;
  localparam int FRAME_NARROW = 1;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  in_item_t             item;
  result_t              result;
  logic                 strobe;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  int       errors;
  int       pending;
  int       idle_cycles = 0;
  int       burst_left = 0;
  bit       gaps_on = 1'b1;
  int       n_items = 0;
  int       frames = 0;
  int       settings = 0;
  logic [3:0] modes_used = '0;

  always #5 clk = ~clk;

  signal_min_max_normalizer u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .result    (result),
    .strobe    (strobe),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  smm_norm_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .result    (result),
    .strobe    (strobe),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no request or result for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic configure(input logic signed [15:0] off, input logic signed [15:0] gain,
                           input logic [1:0] md);
    cfg_we <= 1'b1;
    cfg_index <= REG_OFFSET;
    cfg_data <= off;
    @(posedge clk);
    cfg_index <= REG_SCALE;
    cfg_data <= gain;
    @(posedge clk);
    cfg_index <= REG_MODE;
    cfg_data <= {14'd0, md};
    @(posedge clk);
    cfg_we <= 1'b0;
    modes_used[md] = 1'b1;
    settings++;
  endtask

  // Present one request and hold it until taken; with gaps_on set, gaps open between bursts.
  task automatic push_sample(input logic signed [15:0] s, input logic is_last);
    in_item_t req;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    req.sample = s;
    req.last = is_last;
    start <= 1'b1;
    item <= req;
    do @(posedge clk); while (busy);
    n_items++;
    if (is_last) frames++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_frame(input int len, input int kind);
    logic signed [15:0] level;
    logic signed [15:0] s;
    level = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      case (kind)
        FRAME_WIDE:   s = 16'($urandom);
        FRAME_NARROW: s = 16'($urandom_range(0, 1023) - 512);
        default:      s = level;
      endcase
      push_sample(s, i == len - 1);
    end
  endtask

  initial begin
    logic signed [15:0] off;
    logic signed [15:0] gain;
    logic [1:0]         md;
    int                 len;
    int                 pick;

    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_OFFSET;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Field extremes, single-sample frame.
    configure(16'sd0, 16'sd256, MODE_ADJUSTED);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sd0, 1'b0);
    push_sample(-16'sd1, 1'b1);
    push_sample(16'sh0100, 1'b1);
    // Centered values that saturate.
    wait_drained();
    configure(16'sd0, 16'sd256, MODE_CENTERED);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh8000, 1'b1);
    // Normalized, then flat frames.
    wait_drained();
    configure(16'sd0, 16'sd256, MODE_NORMALIZE);
    push_sample(16'sd100, 1'b0);
    push_sample(-16'sd300, 1'b0);
    push_sample(16'sd2000, 1'b0);
    push_sample(16'sd7, 1'b1);
    push_sample(-16'sd5, 1'b0);
    push_sample(-16'sd5, 1'b1);
    push_sample(16'sd1234, 1'b1);
    // Register extremes in the unused mode, then in centered mode, then a minimal scale in normalize mode.
    wait_drained();
    configure(16'sh8000, 16'sh8000, MODE_UNUSED);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b1);
    wait_drained();
    configure(16'sh7fff, 16'sh7fff, MODE_CENTERED);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sd0, 1'b0);
    push_sample(16'sh8000, 1'b1);
    wait_drained();
    configure(16'sd0, 16'sd1, MODE_NORMALIZE);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sd255, 1'b1);

    // Fill the store past its depth twice, each time with the last request dropped.
    wait_drained();
    configure(16'sd0, 16'sd256, MODE_CENTERED);
    send_frame(SAMPLE_DEPTH + 1, FRAME_WIDE);
    send_frame(SAMPLE_DEPTH + 4, FRAME_NARROW);

    while (n_items < TOTAL_ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 3))
        0:       off = 16'sd0;
        1:       off = 16'($urandom_range(0, 511) - 256);
        2:       off = 16'($urandom);
        default: off = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      endcase
      case ($urandom_range(0, 3))
        0:       gain = 16'sd256;
        1:       gain = 16'($urandom_range(0, 1023) - 512);
        2:       gain = 16'($urandom);
        default: gain = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      endcase
      md = 2'($urandom_range(0, 3));
      configure(off, gain, md);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) len = $urandom_range(1, 6);
        else if (pick < 9) len = $urandom_range(7, 20);
        else len = $urandom_range(21, SAMPLE_DEPTH + 8);
        send_frame(len, $urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    $display("Run covered %0d samples in %0d frames over %0d register settings",
             n_items, frames, settings);
    $display("Modes written (bit per mode): %b, %0d mismatches", modes_used, errors);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
sv/smm_norm_pkg.sv
sv/smm_norm_adjust.sv
sv/smm_norm_div.sv
sv/smm_norm_seq.sv
sv/signal_min_max_normalizer.sv
sv/smm_norm_chk.sv
dv/smm_norm_checker.sv
dv/testbench.sv
